// ===== rtl/core/rvx_pkg.sv =====
`timescale 1ns / 1ps

package rvx_pkg;

  typedef enum logic [1:0] {
    CMD_EXEC  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    CL_JAL,
    CL_JALR,
    CL_BRANCH,
    CL_LOAD,
    CL_STORE,
    CL_AUIPC,
    CL_LUI,
    CL_ALU,
    CL_NOP,
    CL_ILLEGAL
  } cls_t;

  typedef enum logic [3:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_SLL,
    ALU_SLT,
    ALU_SLTU,
    ALU_XOR,
    ALU_SRL,
    ALU_SRA,
    ALU_OR,
    ALU_AND
  } aluop_t;

  typedef enum logic [1:0] {
    BK_RD,
    BK_EX,
    BK_MEM
  } bk_state_t;

  localparam logic [6:0] OPC_JAL    = 7'b110_1111;
  localparam logic [6:0] OPC_JALR   = 7'b110_0111;
  localparam logic [6:0] OPC_BRANCH = 7'b110_0011;
  localparam logic [6:0] OPC_LOAD   = 7'b000_0011;
  localparam logic [6:0] OPC_STORE  = 7'b010_0011;
  localparam logic [6:0] OPC_AUIPC  = 7'b001_0111;
  localparam logic [6:0] OPC_LUI    = 7'b011_0111;
  localparam logic [6:0] OPC_OPIMM  = 7'b001_0011;
  localparam logic [6:0] OPC_OP     = 7'b011_0011;
  localparam logic [6:0] OPC_SYSTEM = 7'b111_0011;

  localparam logic [6:0]  F7_ZERO  = 7'b0000000;
  localparam logic [6:0]  F7_ALT   = 7'b0100000;
  localparam logic [31:0] ECALL_WORD = 32'h0000_0073;
  localparam logic [31:0] UPPER_MASK = 32'hffff_f000;
  localparam int          DATA_SEL_BIT = 28;

  typedef struct packed {
    cmd_t         cmd;
    cls_t         cls;
    aluop_t       aluop;
    logic         use_imm;
    logic [2:0]   f3;
    logic [4:0]   rd;
    logic [4:0]   rs1;
    logic [4:0]   rs2;
    logic [31:0]  imm;
    logic [9:0]   mem_index;
    logic [31:0]  mem_data;
  } dec_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        error_flag;
    logic [31:0] read_data;
    logic        reg_write_en;
    logic [4:0]  reg_dest;
    logic [31:0] reg_value;
    logic        mem_write_en;
    logic [9:0]  mem_write_index;
    logic [31:0] mem_write_value;
  } result_t;

endpackage

// ===== rtl/core/rvx_ram.sv =====
`timescale 1ns / 1ps

module rvx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== rtl/core/rvx_fifo.sv =====
`timescale 1ns / 1ps

module rvx_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/rvx_front.sv =====
`timescale 1ns / 1ps

module rvx_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  logic [1:0]      cmd,
  input  logic [31:0]     instruction,
  input  logic [9:0]      mem_index,
  input  logic [31:0]     mem_data,
  input  logic            pop,
  output logic            head_valid,
  output rvx_pkg::dec_t   head
);

  rvx_pkg::dec_t dec;
  logic [6:0]  op, f7;
  logic [2:0]  f3;
  logic [31:0] immi, imms, immb, immj, immu;
  logic        q_empty;

  assign op   = instruction[6:0];
  assign f3   = instruction[14:12];
  assign f7   = instruction[31:25];
  assign immi = {{20{instruction[31]}}, instruction[31:20]};
  assign imms = {{20{instruction[31]}}, instruction[31:25], instruction[11:7]};
  assign immb = {{19{instruction[31]}}, instruction[31], instruction[7],
                 instruction[30:25], instruction[11:8], 1'b0};
  assign immj = {{11{instruction[31]}}, instruction[31], instruction[19:12],
                 instruction[20], instruction[30:21], 1'b0};
  assign immu = instruction & rvx_pkg::UPPER_MASK;

  // Classify the word.
  always_comb begin
    dec           = '0;
    dec.cmd       = rvx_pkg::cmd_t'(cmd);
    dec.f3        = f3;
    dec.rd        = instruction[11:7];
    dec.rs1       = instruction[19:15];
    dec.rs2       = instruction[24:20];
    dec.mem_index = mem_index;
    dec.mem_data  = mem_data;
    dec.aluop     = rvx_pkg::ALU_ADD;
    dec.cls       = rvx_pkg::CL_ILLEGAL;
    case (op)
      rvx_pkg::OPC_JAL: begin
        dec.cls = rvx_pkg::CL_JAL;
        dec.imm = immj;
      end
      rvx_pkg::OPC_JALR: begin
        dec.cls = (f3 == 3'd0) ? rvx_pkg::CL_JALR : rvx_pkg::CL_ILLEGAL;
        dec.imm = immi;
      end
      rvx_pkg::OPC_BRANCH: begin
        dec.cls = (f3 inside {3'd2, 3'd3}) ? rvx_pkg::CL_ILLEGAL : rvx_pkg::CL_BRANCH;
        dec.imm = immb;
      end
      rvx_pkg::OPC_LOAD: begin
        dec.cls = (f3 inside {3'd3, 3'd6, 3'd7}) ? rvx_pkg::CL_ILLEGAL : rvx_pkg::CL_LOAD;
        dec.imm = immi;
      end
      rvx_pkg::OPC_STORE: begin
        dec.cls = (f3 > 3'd2) ? rvx_pkg::CL_ILLEGAL : rvx_pkg::CL_STORE;
        dec.imm = imms;
      end
      rvx_pkg::OPC_AUIPC: begin
        dec.cls = rvx_pkg::CL_AUIPC;
        dec.imm = immu;
      end
      rvx_pkg::OPC_LUI: begin
        dec.cls = rvx_pkg::CL_LUI;
        dec.imm = immu;
      end
      rvx_pkg::OPC_OPIMM: begin
        dec.cls     = rvx_pkg::CL_ALU;
        dec.imm     = immi;
        dec.use_imm = 1'b1;
        case (f3)
          3'd0: dec.aluop = rvx_pkg::ALU_ADD;
          3'd2: dec.aluop = rvx_pkg::ALU_SLT;
          3'd3: dec.aluop = rvx_pkg::ALU_SLTU;
          3'd4: dec.aluop = rvx_pkg::ALU_XOR;
          3'd6: dec.aluop = rvx_pkg::ALU_OR;
          3'd7: dec.aluop = rvx_pkg::ALU_AND;
          3'd1: begin
            if (f7 == rvx_pkg::F7_ZERO) dec.aluop = rvx_pkg::ALU_SLL;
            else dec.cls = rvx_pkg::CL_ILLEGAL;
          end
          default: begin
            if (f7 == rvx_pkg::F7_ZERO) dec.aluop = rvx_pkg::ALU_SRL;
            else if (f7 == rvx_pkg::F7_ALT) dec.aluop = rvx_pkg::ALU_SRA;
            else dec.cls = rvx_pkg::CL_ILLEGAL;
          end
        endcase
      end
      rvx_pkg::OPC_OP: begin
        dec.cls = rvx_pkg::CL_ALU;
        if (f7 == rvx_pkg::F7_ALT && f3 == 3'd0) begin
          dec.aluop = rvx_pkg::ALU_SUB;
        end else if (f7 == rvx_pkg::F7_ALT && f3 == 3'd5) begin
          dec.aluop = rvx_pkg::ALU_SRA;
        end else if (f7 != rvx_pkg::F7_ZERO) begin
          dec.cls = rvx_pkg::CL_ILLEGAL;
        end else begin
          case (f3)
            3'd0:    dec.aluop = rvx_pkg::ALU_ADD;
            3'd1:    dec.aluop = rvx_pkg::ALU_SLL;
            3'd2:    dec.aluop = rvx_pkg::ALU_SLT;
            3'd3:    dec.aluop = rvx_pkg::ALU_SLTU;
            3'd4:    dec.aluop = rvx_pkg::ALU_XOR;
            3'd5:    dec.aluop = rvx_pkg::ALU_SRL;
            3'd6:    dec.aluop = rvx_pkg::ALU_OR;
            default: dec.aluop = rvx_pkg::ALU_AND;
          endcase
        end
      end
      rvx_pkg::OPC_SYSTEM: begin
        dec.cls = (instruction == rvx_pkg::ECALL_WORD) ? rvx_pkg::CL_NOP
                                                       : rvx_pkg::CL_ILLEGAL;
      end
      default: dec.cls = rvx_pkg::CL_ILLEGAL;
    endcase
  end

  rvx_fifo #(
    .WIDTH($bits(rvx_pkg::dec_t)),
    .DEPTH(2)
  ) u_dec_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (dec),
    .full  (full),
    .pop   (pop),
    .dout  (head),
    .empty (q_empty)
  );

  assign head_valid = !q_empty;

endmodule

// ===== rtl/core/rvx_back.sv =====
`timescale 1ns / 1ps

module rvx_back #(
  parameter int MEM_WORDS = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  rvx_pkg::dec_t    head,
  output logic             head_pop,
  input  logic             res_full,
  output logic             res_push,
  output rvx_pkg::result_t res
);

  localparam int AW = $clog2(MEM_WORDS);

  rvx_pkg::bk_state_t state_r, state_nxt;
  rvx_pkg::result_t   ex_res, mem_res, sv_res_r;
  logic [31:0]   pc_r;
  logic          err_r;
  logic [31:0]   rf_vld_r;
  logic [31:0]   rf_a_q, rf_b_q, s1, s2, opb, alu, ex_addr;
  logic [31:0]   dm_q, ld_word, st_mask, st_word;
  logic          rf_we, dm_we;
  logic [AW-1:0] ex_widx, widx_r, dm_raddr, dm_waddr;
  logic [31:0]   dm_wdata;
  logic [1:0]    lane_r, al;
  logic          idx_ok, addr_ok, rd_ok_r, take, ex_go_mem, finish;

  rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
    .clk(clk), .we(rf_we), .waddr(res.reg_dest), .wdata(res.reg_value),
    .raddr(head.rs1), .rdata(rf_a_q)
  );
  rvx_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
    .clk(clk), .we(rf_we), .waddr(res.reg_dest), .wdata(res.reg_value),
    .raddr(head.rs2), .rdata(rf_b_q)
  );
  rvx_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_dm (
    .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
    .raddr(dm_raddr), .rdata(dm_q)
  );

  // Unwritten registers and x0 read zero.
  assign s1  = rf_vld_r[head.rs1] ? rf_a_q : '0;
  assign s2  = rf_vld_r[head.rs2] ? rf_b_q : '0;
  assign opb = head.use_imm ? head.imm : s2;
  assign ex_addr = s1 + head.imm;
  assign idx_ok  = ({22'd0, head.mem_index} < 32'(MEM_WORDS));
  assign al      = (head.f3[1:0] == 2'd0) ? 2'd0 : ((head.f3[1:0] == 2'd1) ? 2'd1 : 2'd3);
  assign addr_ok = ex_addr[rvx_pkg::DATA_SEL_BIT] && ((ex_addr[1:0] & al) == 2'd0) &&
                   ({6'd0, ex_addr[27:2]} < 32'(MEM_WORDS));
  assign ex_widx = (head.cmd == rvx_pkg::CMD_READ) ? AW'(head.mem_index) : AW'(ex_addr[27:2]);

  always_comb begin
    case (head.aluop)
      rvx_pkg::ALU_ADD:  alu = s1 + opb;
      rvx_pkg::ALU_SUB:  alu = s1 - opb;
      rvx_pkg::ALU_SLL:  alu = s1 << opb[4:0];
      rvx_pkg::ALU_SLT:  alu = {31'd0, $signed(s1) < $signed(opb)};
      rvx_pkg::ALU_SLTU: alu = {31'd0, s1 < opb};
      rvx_pkg::ALU_XOR:  alu = s1 ^ opb;
      rvx_pkg::ALU_SRL:  alu = s1 >> opb[4:0];
      rvx_pkg::ALU_SRA:  alu = 32'($signed(s1) >>> opb[4:0]);
      rvx_pkg::ALU_OR:   alu = s1 | opb;
      rvx_pkg::ALU_AND:  alu = s1 & opb;
      default:           alu = '0;
    endcase
  end

  always_comb begin
    case (head.f3)
      3'd0:    take = (s1 == s2);
      3'd1:    take = (s1 != s2);
      3'd4:    take = ($signed(s1) < $signed(s2));
      3'd5:    take = !($signed(s1) < $signed(s2));
      3'd6:    take = (s1 < s2);
      3'd7:    take = (s1 >= s2);
      default: take = 1'b0;
    endcase
  end

  // Execute step: everything but the data store read.
  always_comb begin
    logic err;
    err       = 1'b0;
    ex_go_mem = 1'b0;
    ex_res    = '0;
    ex_res.next_pc = pc_r;
    case (head.cmd)
      rvx_pkg::CMD_READ: ex_go_mem = 1'b1;
      rvx_pkg::CMD_EXEC: begin
        ex_res.next_pc = pc_r + 32'd4;
        err = (pc_r[1:0] != 2'd0);
        case (head.cls)
          rvx_pkg::CL_JAL: begin
            ex_res.reg_write_en = 1'b1;
            ex_res.reg_value    = pc_r + 32'd4;
            ex_res.next_pc      = pc_r + head.imm;
          end
          rvx_pkg::CL_JALR: begin
            ex_res.reg_write_en = 1'b1;
            ex_res.reg_value    = pc_r + 32'd4;
            ex_res.next_pc      = {ex_addr[31:1], 1'b0};
          end
          rvx_pkg::CL_BRANCH: begin
            if (take) ex_res.next_pc = pc_r + head.imm;
          end
          rvx_pkg::CL_LOAD, rvx_pkg::CL_STORE: begin
            if (addr_ok) ex_go_mem = 1'b1;
            else err = 1'b1;
          end
          rvx_pkg::CL_AUIPC: begin
            ex_res.reg_write_en = 1'b1;
            ex_res.reg_value    = head.imm + pc_r;
          end
          rvx_pkg::CL_LUI: begin
            ex_res.reg_write_en = 1'b1;
            ex_res.reg_value    = head.imm;
          end
          rvx_pkg::CL_ALU: begin
            // A misaligned fetch already flagged blocks the write here.
            if (!err) begin
              ex_res.reg_write_en = 1'b1;
              ex_res.reg_value    = alu;
            end
          end
          rvx_pkg::CL_NOP: ;
          default: err = 1'b1;
        endcase
        if (ex_res.reg_write_en) ex_res.reg_dest = head.rd;
      end
      default: ;
    endcase
    ex_res.error_flag = err_r | err;
  end

  // Data store step for loads, stores and readback.
  assign ld_word = dm_q >> {lane_r, 3'b000};
  assign st_mask = ((head.f3[1:0] == 2'd0) ? 32'h0000_00ff :
                    (head.f3[1:0] == 2'd1) ? 32'h0000_ffff : 32'hffff_ffff)
                   << {lane_r, 3'b000};
  assign st_word = (dm_q & ~st_mask) | ((s2 << {lane_r, 3'b000}) & st_mask);

  always_comb begin
    mem_res = sv_res_r;
    if (head.cmd == rvx_pkg::CMD_READ) begin
      mem_res.read_data = rd_ok_r ? dm_q : '0;
    end else if (head.cls == rvx_pkg::CL_LOAD) begin
      mem_res.reg_write_en = 1'b1;
      mem_res.reg_dest     = head.rd;
      case (head.f3)
        3'd0:    mem_res.reg_value = {{24{ld_word[7]}}, ld_word[7:0]};
        3'd1:    mem_res.reg_value = {{16{ld_word[15]}}, ld_word[15:0]};
        3'd4:    mem_res.reg_value = {24'd0, ld_word[7:0]};
        3'd5:    mem_res.reg_value = {16'd0, ld_word[15:0]};
        default: mem_res.reg_value = ld_word;
      endcase
    end else begin
      mem_res.mem_write_en    = 1'b1;
      mem_res.mem_write_index = 10'(widx_r);
      mem_res.mem_write_value = st_word;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rvx_pkg::BK_RD:  if (head_valid) state_nxt = rvx_pkg::BK_EX;
      rvx_pkg::BK_EX: begin
        if (ex_go_mem) state_nxt = rvx_pkg::BK_MEM;
        else if (!res_full) state_nxt = rvx_pkg::BK_RD;
      end
      rvx_pkg::BK_MEM: if (!res_full) state_nxt = rvx_pkg::BK_RD;
      default: state_nxt = rvx_pkg::BK_RD;
    endcase
  end

  always_comb begin
    finish   = ((state_r == rvx_pkg::BK_EX) && !ex_go_mem && !res_full) ||
               ((state_r == rvx_pkg::BK_MEM) && !res_full);
    res      = (state_r == rvx_pkg::BK_MEM) ? mem_res : ex_res;
    res_push = finish;
    head_pop = finish;
    rf_we    = finish && res.reg_write_en && (res.reg_dest != 5'd0);
    dm_raddr = (state_r == rvx_pkg::BK_EX) ? ex_widx : widx_r;
    if (state_r == rvx_pkg::BK_EX) begin
      dm_we    = finish && (head.cmd == rvx_pkg::CMD_WRITE) && idx_ok;
      dm_waddr = AW'(head.mem_index);
      dm_wdata = head.mem_data;
    end else begin
      dm_we    = finish && (head.cmd == rvx_pkg::CMD_EXEC) && (head.cls == rvx_pkg::CL_STORE);
      dm_waddr = widx_r;
      dm_wdata = st_word;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == rvx_pkg::BK_EX) && ex_go_mem) begin
      sv_res_r <= ex_res;
      widx_r   <= ex_widx;
      lane_r   <= ex_addr[1:0];
      rd_ok_r  <= idx_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= rvx_pkg::BK_RD;
      pc_r     <= '0;
      err_r    <= 1'b0;
      rf_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (finish) begin
        pc_r  <= res.next_pc;
        err_r <= res.error_flag;
      end
      if (rf_we) rf_vld_r[res.reg_dest] <= 1'b1;
    end
  end

endmodule

// ===== rtl/core/rv32i_instruction_executor_top.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake           | Fields
// ---------+---------------------+------------------------------------------------
// input    | in_push / in_full   | in_cmd, in_instruction, in_mem_index, in_mem_data
// result   | out_pop / out_empty | out_next_pc, out_error_flag, out_read_data, ...
//
// Each word passes the register file read and execute states of the back end;
// valid loads and stores and data readback add a state for the data store read port.
// A two-word decode queue and a two-word result queue decouple both sides.
// rst_n is synchronous: pc, sticky error and register valid bits clear at once.
// The data store is not cleared; it must be preloaded before it is read.
// A full result queue holds the back end; a full decode queue raises in_full.
module rv32i_instruction_executor_top #(
  parameter int MEM_WORDS = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_cmd,
  input  logic [31:0] in_instruction,
  input  logic [9:0]  in_mem_index,
  input  logic [31:0] in_mem_data,
  input  logic        out_pop,
  output logic        out_empty,
  output logic [31:0] out_next_pc,
  output logic        out_error_flag,
  output logic [31:0] out_read_data,
  output logic        out_reg_write_en,
  output logic [4:0]  out_reg_dest,
  output logic [31:0] out_reg_value,
  output logic        out_mem_write_en,
  output logic [9:0]  out_mem_write_index,
  output logic [31:0] out_mem_write_value
);

  rvx_pkg::dec_t    head;
  rvx_pkg::result_t res, res_q;
  logic head_valid, head_pop, res_full, res_push;

  // Front: decode each word into a class and push it to the decode queue.
  rvx_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (in_push),
    .full        (in_full),
    .cmd         (in_cmd),
    .instruction (in_instruction),
    .mem_index   (in_mem_index),
    .mem_data    (in_mem_data),
    .pop         (head_pop),
    .head_valid  (head_valid),
    .head        (head)
  );

  // Back: register file, execute and data store; advance when the result fits.
  rvx_back #(.MEM_WORDS(MEM_WORDS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  // Result queue: hold finished words until popped.
  rvx_fifo #(
    .WIDTH($bits(rvx_pkg::result_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (res_q),
    .empty (out_empty)
  );

  assign out_next_pc         = res_q.next_pc;
  assign out_error_flag      = res_q.error_flag;
  assign out_read_data       = res_q.read_data;
  assign out_reg_write_en    = res_q.reg_write_en;
  assign out_reg_dest        = res_q.reg_dest;
  assign out_reg_value       = res_q.reg_value;
  assign out_mem_write_en    = res_q.mem_write_en;
  assign out_mem_write_index = res_q.mem_write_index;
  assign out_mem_write_value = res_q.mem_write_value;

endmodule

// ===== bench/tb_rv32i_instruction_executor_top.sv =====
`timescale 1ns / 1ps

module tb_rv32i_instruction_executor_top;

  localparam int DMEM_WORDS = 1024;
  localparam int IDLE_LIMIT = 5000;
  localparam int REPORT_MAX = 10;

  // Expected-result store plus a private copy of the architectural state.
  class exec_scoreboard;
    logic [31:0]      pc;
    logic             sticky;
    logic [31:0]      regs[32];
    logic [31:0]      dmem[DMEM_WORDS];
    rvx_pkg::result_t expected_q[$];
    int               mismatches;
    int               n_checked;
    int               n_exec;
    int               n_mem_cmd;

    function new();
      pc = '0;
      sticky = 1'b0;
      foreach (regs[i]) regs[i] = '0;
      mismatches = 0;
      n_checked = 0;
      n_exec = 0;
      n_mem_cmd = 0;
    endfunction

    // Resolve a data address; 0 when bit 28 is clear, misaligned or out of range.
    function bit data_addr(logic [31:0] a, logic [1:0] al, output int widx,
                           output logic [1:0] lane);
      logic [31:0] m;
      m = a & 32'h0FFF_FFFF;
      widx = m >> 2;
      lane = m[1:0];
      if (!a[rvx_pkg::DATA_SEL_BIT]) return 0;
      if ((m[1:0] & al) != 0) return 0;
      if ((m >> 2) >= DMEM_WORDS) return 0;
      return 1;
    endfunction

    // Predict the result of one accepted word and queue it.
    function void note_input(rvx_pkg::cmd_t cmd, logic [31:0] ins, logic [9:0] idx,
                             logic [31:0] dat);
      rvx_pkg::result_t r;
      logic [6:0]  op;
      logic [2:0]  f3;
      logic [6:0]  f7;
      logic [31:0] s1, s2, immi, imms, immb, immj, immu, npc, val, w, mask;
      logic [4:0]  rd;
      logic [1:0]  al, lane;
      int          widx;
      bit          err, wen, take;
      r = '0;
      if (cmd == rvx_pkg::CMD_WRITE) begin
        dmem[idx] = dat;
        n_mem_cmd++;
      end else if (cmd == rvx_pkg::CMD_READ) begin
        r.read_data = dmem[idx];
        n_mem_cmd++;
      end else if (cmd == rvx_pkg::CMD_EXEC) begin
        n_exec++;
        op = ins[6:0];
        f3 = ins[14:12];
        f7 = ins[31:25];
        s1 = regs[ins[19:15]];
        s2 = regs[ins[24:20]];
        immi = {{20{ins[31]}}, ins[31:20]};
        imms = {{20{ins[31]}}, ins[31:25], ins[11:7]};
        immb = {{19{ins[31]}}, ins[31], ins[7], ins[30:25], ins[11:8], 1'b0};
        immj = {{11{ins[31]}}, ins[31], ins[19:12], ins[20], ins[30:21], 1'b0};
        immu = ins & rvx_pkg::UPPER_MASK;
        npc = pc + 4;
        rd = ins[11:7];
        val = '0;
        err = (pc[1:0] != 2'b00);
        wen = 0;
        take = 0;
        case (op)
          rvx_pkg::OPC_JAL: begin
            wen = 1; val = pc + 4; npc = pc + immj;
          end
          rvx_pkg::OPC_JALR: begin
            if (f3 != 0) err = 1;
            else begin
              wen = 1; val = pc + 4; npc = (s1 + immi) & ~32'd1;
            end
          end
          rvx_pkg::OPC_BRANCH: begin
            case (f3)
              3'd0: take = (s1 == s2);
              3'd1: take = (s1 != s2);
              3'd4: take = ($signed(s1) < $signed(s2));
              3'd5: take = !($signed(s1) < $signed(s2));
              3'd6: take = (s1 < s2);
              3'd7: take = (s1 >= s2);
              default: err = 1;
            endcase
            if (take) npc = pc + immb;
          end
          rvx_pkg::OPC_LOAD: begin
            al = (f3[1:0] == 0) ? 2'd0 : ((f3[1:0] == 1) ? 2'd1 : 2'd3);
            if (f3 == 3 || f3 > 5) err = 1;
            else if (!data_addr(s1 + immi, al, widx, lane)) err = 1;
            else begin
              w = dmem[widx] >> (lane * 8);
              case (f3)
                3'd0: val = {{24{w[7]}}, w[7:0]};
                3'd1: val = {{16{w[15]}}, w[15:0]};
                3'd2: val = w;
                3'd4: val = {24'd0, w[7:0]};
                default: val = {16'd0, w[15:0]};
              endcase
              wen = 1;
            end
          end
          rvx_pkg::OPC_STORE: begin
            al = (f3 == 0) ? 2'd0 : ((f3 == 1) ? 2'd1 : 2'd3);
            if (f3 > 2) err = 1;
            else if (!data_addr(s1 + imms, al, widx, lane)) err = 1;
            else begin
              mask = (f3 == 0) ? 32'hFF : ((f3 == 1) ? 32'hFFFF : 32'hFFFF_FFFF);
              mask = mask << (lane * 8);
              w = (dmem[widx] & ~mask) | ((s2 << (lane * 8)) & mask);
              dmem[widx] = w;
              r.mem_write_en = 1'b1;
              r.mem_write_index = widx[9:0];
              r.mem_write_value = w;
            end
          end
          rvx_pkg::OPC_AUIPC: begin wen = 1; val = immu + pc; end
          rvx_pkg::OPC_LUI: begin wen = 1; val = immu; end
          rvx_pkg::OPC_OPIMM: begin
            case (f3)
              3'd0: val = s1 + immi;
              3'd2: val = ($signed(s1) < $signed(immi)) ? 32'd1 : 32'd0;
              3'd3: val = (s1 < immi) ? 32'd1 : 32'd0;
              3'd4: val = s1 ^ immi;
              3'd6: val = s1 | immi;
              3'd7: val = s1 & immi;
              3'd1: begin
                if (f7 != rvx_pkg::F7_ZERO) err = 1; else val = s1 << immi[4:0];
              end
              default: begin
                if (f7 == rvx_pkg::F7_ZERO) val = s1 >> immi[4:0];
                else if (f7 == rvx_pkg::F7_ALT) val = $signed(s1) >>> immi[4:0];
                else err = 1;
              end
            endcase
            if (!err) wen = 1;
          end
          rvx_pkg::OPC_OP: begin
            if (f7 == rvx_pkg::F7_ALT && f3 == 0) val = s1 - s2;
            else if (f7 == rvx_pkg::F7_ALT && f3 == 5) val = $signed(s1) >>> s2[4:0];
            else if (f7 != rvx_pkg::F7_ZERO) err = 1;
            else begin
              case (f3)
                3'd0: val = s1 + s2;
                3'd1: val = s1 << s2[4:0];
                3'd2: val = ($signed(s1) < $signed(s2)) ? 32'd1 : 32'd0;
                3'd3: val = (s1 < s2) ? 32'd1 : 32'd0;
                3'd4: val = s1 ^ s2;
                3'd5: val = s1 >> s2[4:0];
                3'd6: val = s1 | s2;
                default: val = s1 & s2;
              endcase
            end
            if (!err) wen = 1;
          end
          rvx_pkg::OPC_SYSTEM: begin
            if (ins != rvx_pkg::ECALL_WORD) err = 1;
          end
          default: err = 1;
        endcase
        // Err may have been raised after a tentative write on a misaligned fetch.
        if (wen) begin
          if (rd != 0) regs[rd] = val;
        end else begin
          rd = '0;
          val = '0;
        end
        if (err) sticky = 1'b1;
        pc = npc;
        r.reg_write_en = wen;
        r.reg_dest = rd;
        r.reg_value = val;
      end
      r.next_pc = pc;
      r.error_flag = sticky;
      expected_q.push_back(r);
    endfunction

    function void check_result(rvx_pkg::result_t act);
      rvx_pkg::result_t e;
      n_checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected result word %p", $realtime, act);
        return;
      end
      e = expected_q.pop_front();
      if (act !== e) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("%0t: result mismatch", $realtime);
          $display("  next_pc    exp %h act %h", e.next_pc, act.next_pc);
          $display("  error_flag exp %b act %b", e.error_flag, act.error_flag);
          $display("  read_data  exp %h act %h", e.read_data, act.read_data);
          $display("  reg write  exp %b x%0d %h act %b x%0d %h", e.reg_write_en,
                   e.reg_dest, e.reg_value, act.reg_write_en, act.reg_dest,
                   act.reg_value);
          $display("  mem write  exp %b %0d %h act %b %0d %h", e.mem_write_en,
                   e.mem_write_index, e.mem_write_value, act.mem_write_en,
                   act.mem_write_index, act.mem_write_value);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_cmd;
  logic [31:0] in_instruction;
  logic [9:0]  in_mem_index;
  logic [31:0] in_mem_data;
  logic        out_pop;
  logic        out_empty;
  logic [31:0] out_next_pc;
  logic        out_error_flag;
  logic [31:0] out_read_data;
  logic        out_reg_write_en;
  logic [4:0]  out_reg_dest;
  logic [31:0] out_reg_value;
  logic        out_mem_write_en;
  logic [9:0]  out_mem_write_index;
  logic [31:0] out_mem_write_value;

  exec_scoreboard sb;
  bit quiet;      // no idling on either side while set
  int idle_cycles;

  rv32i_instruction_executor_top #(.MEM_WORDS(DMEM_WORDS)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_cmd(in_cmd),
    .in_instruction(in_instruction), .in_mem_index(in_mem_index),
    .in_mem_data(in_mem_data),
    .out_pop(out_pop), .out_empty(out_empty), .out_next_pc(out_next_pc),
    .out_error_flag(out_error_flag), .out_read_data(out_read_data),
    .out_reg_write_en(out_reg_write_en), .out_reg_dest(out_reg_dest),
    .out_reg_value(out_reg_value), .out_mem_write_en(out_mem_write_en),
    .out_mem_write_index(out_mem_write_index),
    .out_mem_write_value(out_mem_write_value)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Encoders for the RV32I formats.
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, rvx_pkg::OPC_OP};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], rvx_pkg::OPC_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rvx_pkg::OPC_BRANCH};
  endfunction

  function automatic logic [31:0] enc_u(logic [19:0] imm, logic [4:0] rd, logic [6:0] op);
    return {imm, rd, op};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rvx_pkg::OPC_JAL};
  endfunction

  // Drive one word after a random gap; hold it until the block takes it.
  task automatic send_word(rvx_pkg::cmd_t cmd, logic [31:0] ins, logic [9:0] idx,
                           logic [31:0] dat);
    int gap, r;
    r = $urandom_range(0, 99);
    gap = quiet ? 0 : (r < 70 ? 0 : (r < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40)));
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_cmd <= cmd;
    in_instruction <= ins;
    in_mem_index <= idx;
    in_mem_data <= dat;
    do @(posedge clk); while (in_full);
    sb.note_input(cmd, ins, idx, dat);
  endtask

  task automatic exec(logic [31:0] ins);
    send_word(rvx_pkg::CMD_EXEC, ins, 10'($urandom), $urandom);
  endtask

  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  // One legal instruction (two words for loads and stores) that keeps pc aligned.
  task automatic clean_instr();
    logic [4:0]  rd, rs1, rs2, rb;
    logic [2:0]  f3;
    logic [11:0] imm;
    logic [1:0]  al;
    int          kind;
    rd = 5'($urandom);
    rs1 = 5'($urandom);
    rs2 = 5'($urandom);
    f3 = 3'($urandom);
    kind = $urandom_range(0, 11);
    case (kind)
      0, 1: exec(enc_r(((f3 == 0 || f3 == 5) && $urandom_range(0, 1)) ? rvx_pkg::F7_ALT
                                                                      : rvx_pkg::F7_ZERO,
                       rs2, rs1, f3, rd));
      2, 3: begin
        imm = 12'($urandom);
        if (f3 == 1) imm = {7'd0, imm[4:0]};
        if (f3 == 5) imm = {$urandom_range(0, 1) ? rvx_pkg::F7_ALT : rvx_pkg::F7_ZERO,
                            imm[4:0]};
        exec(enc_i(imm, rs1, f3, rd, rvx_pkg::OPC_OPIMM));
      end
      4: exec(enc_u(20'($urandom), rd,
                    $urandom_range(0, 1) ? rvx_pkg::OPC_LUI : rvx_pkg::OPC_AUIPC));
      5: exec(enc_j(21'($urandom_range(0, 255) * 4 - 512), rd));
      6: exec(enc_i(12'($urandom_range(0, 511) * 4), 5'd0, 3'd0, rd, rvx_pkg::OPC_JALR));
      7: begin
        while (f3 == 2 || f3 == 3) f3 = 3'($urandom);
        exec(enc_b(13'($urandom_range(0, 127) * 4 - 256), rs2, rs1, f3));
      end
      8, 9, 10: begin
        // Point a base register at the data window, then access it.
        rb = 5'($urandom_range(1, 31));
        exec(enc_u(20'h10000, rb, rvx_pkg::OPC_LUI));
        if (kind == 10) begin
          f3 = 3'($urandom_range(0, 2));
          al = (f3 == 0) ? 2'd0 : (f3 == 1 ? 2'd1 : 2'd3);
          exec(enc_s(12'($urandom_range(0, 2047)) & ~12'(al), rs2, rb, f3));
        end else begin
          while (f3 == 3 || f3 > 5) f3 = 3'($urandom);
          al = (f3[1:0] == 0) ? 2'd0 : (f3[1:0] == 1 ? 2'd1 : 2'd3);
          exec(enc_i(12'($urandom_range(0, 2047)) & ~12'(al), rb, f3, rd,
                     rvx_pkg::OPC_LOAD));
        end
      end
      default: exec(rvx_pkg::ECALL_WORD);
    endcase
  endtask

  // Result side: random pop stalls, mostly short, a few long.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty)
        sb.check_result('{out_next_pc, out_error_flag, out_read_data, out_reg_write_en,
                          out_reg_dest, out_reg_value, out_mem_write_en,
                          out_mem_write_index, out_mem_write_value});
      if (quiet) stall = 0;
      else if (stall == 0) begin
        if ($urandom_range(0, 99) < 15) stall = $urandom_range(1, 3);
        else if ($urandom_range(0, 199) == 0) stall = $urandom_range(20, 60);
      end
      if (stall > 0) begin
        out_pop <= 1'b0;
        stall--;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when neither side has moved a word for too long.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
        $display("tb_rv32i_instruction_executor_top: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int i, k;
    sb = new();
    quiet = 1'b0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_cmd = rvx_pkg::CMD_NONE;
    in_instruction = '0;
    in_mem_index = '0;
    in_mem_data = '0;
    out_pop = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Preload the whole data store so no access ever reads an unwritten word.
    for (i = 0; i < DMEM_WORDS; i++)
      send_word(rvx_pkg::CMD_WRITE, $urandom, 10'(i), (i == 0) ? 32'hFFFF_FFFF :
                                                       (i == 1) ? 32'h0 : $urandom);

    // Directed legal cases: immediate extremes, signed/unsigned compares,
    // x0 writes, byte sign extension, lane merge, readback and the idle cmd.
    exec(enc_i(12'h800, 5'd0, 3'd0, 5'd1, rvx_pkg::OPC_OPIMM));
    exec(enc_i(12'h7FF, 5'd0, 3'd0, 5'd2, rvx_pkg::OPC_OPIMM));
    exec(enc_u(20'hFFFFF, 5'd3, rvx_pkg::OPC_LUI));
    exec(enc_u(20'h80000, 5'd4, rvx_pkg::OPC_LUI));
    exec(enc_r(rvx_pkg::F7_ALT, 5'd2, 5'd4, 3'd0, 5'd5));
    exec(enc_r(rvx_pkg::F7_ALT, 5'd2, 5'd4, 3'd5, 5'd6));
    exec(enc_r(rvx_pkg::F7_ZERO, 5'd4, 5'd2, 3'd2, 5'd7));
    exec(enc_r(rvx_pkg::F7_ZERO, 5'd4, 5'd2, 3'd3, 5'd8));
    exec(enc_i(12'd5, 5'd2, 3'd0, 5'd0, rvx_pkg::OPC_OPIMM));
    exec(enc_u(20'h10000, 5'd9, rvx_pkg::OPC_LUI));
    exec(enc_i(12'd3, 5'd9, 3'd0, 5'd10, rvx_pkg::OPC_LOAD));
    exec(enc_s(12'd6, 5'd1, 5'd9, 3'd1));
    exec(enc_i(12'd4, 5'd9, 3'd5, 5'd11, rvx_pkg::OPC_LOAD));
    send_word(rvx_pkg::CMD_READ, 32'h0, 10'd1, 32'h0);
    send_word(rvx_pkg::CMD_NONE, $urandom, 10'($urandom), $urandom);
    exec(rvx_pkg::ECALL_WORD);
    exec(enc_j(21'h1FFFFC, 5'd12));

    // Long legal stretch before any error makes the flag stick.
    for (i = 0; i < 200; i++) begin
      quiet = (i >= 80 && i < 130);
      clean_instr();
      if ($urandom_range(0, 9) == 0)
        send_word($urandom_range(0, 1) ? rvx_pkg::CMD_WRITE : rvx_pkg::CMD_READ, 32'd0,
                  10'($urandom), $urandom);
    end
    quiet = 1'b0;
    // Hold the sender until every result has been popped.
    wait_drained();

    // Directed error cases.
    exec(enc_i(12'd2, 5'd0, 3'd0, 5'd13, rvx_pkg::OPC_JALR));  // misaligned jump target
    exec(rvx_pkg::ECALL_WORD);                                 // fetch at a misaligned pc
    exec(enc_i(12'd0, 5'd0, 3'd0, 5'd0, rvx_pkg::OPC_JALR));
    exec(enc_i(12'd0, 5'd0, 3'd2, 5'd14, rvx_pkg::OPC_LOAD));  // bit 28 clear
    exec(enc_u(20'h10001, 5'd15, rvx_pkg::OPC_LUI));
    exec(enc_s(12'd0, 5'd1, 5'd15, 3'd2));                     // index past the store
    exec(enc_i(12'd2, 5'd9, 3'd2, 5'd14, rvx_pkg::OPC_LOAD));  // misaligned word
    exec(32'h0000_000F);                                       // fence
    exec(32'h0010_0073);                                       // ebreak
    exec(enc_i(12'd0, 5'd0, 3'd1, 5'd1, rvx_pkg::OPC_JALR));
    exec(enc_b(13'd8, 5'd0, 5'd0, 3'd2));
    exec(enc_i(12'd0, 5'd9, 3'd3, 5'd1, rvx_pkg::OPC_LOAD));
    exec(enc_s(12'd0, 5'd0, 5'd9, 3'd3));
    exec(enc_r(7'h01, 5'd1, 5'd2, 3'd0, 5'd3));
    exec(32'hFFFF_FFFF);

    // Random mix: legal sequences, raw words, data commands and idle commands.
    for (i = 0; i < 200; i++) begin
      k = $urandom_range(0, 99);
      if (k < 55) clean_instr();
      else if (k < 80) exec($urandom);
      else if (k < 95) send_word($urandom_range(0, 1) ? rvx_pkg::CMD_WRITE
                                                      : rvx_pkg::CMD_READ,
                                 $urandom, 10'($urandom), $urandom);
      else send_word(rvx_pkg::CMD_NONE, $urandom, 10'($urandom), $urandom);
    end
    in_push <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d instructions and %0d data commands, %0d results checked",
             sb.n_exec, sb.n_mem_cmd, sb.n_checked);
    $display("legal stretch, error cases and random words with stalls on both sides");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb_rv32i_instruction_executor_top: PASS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("tb_rv32i_instruction_executor_top: FAIL");
    end
    $finish;
  end

endmodule
